// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pps_pkg
// Types, register indexes, microcode fields and fixed-point constants shared
// by the position PID step sequencer and its datapath.
// ============================================================================
package pps_pkg;

    localparam int STEP_W = 4;
    localparam int ERR_W  = 17;
    localparam int DIFF_W = 18;
    localparam int GAIN_W = 15;
    localparam int INT_W  = 48;
    localparam int MA_W   = 34;
    localparam int MB_W   = 27;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 64;
    localparam int MAG_W  = 25;
    localparam int Q_W    = 14;

    typedef struct packed {
        logic [15:0] distance;
        logic [9:0]  gain_pot;
    } t_pid_in;

    typedef struct packed {
        logic signed [14:0] angle_target;
        logic               clamped;
    } t_pid_out;

    // register indexes
    localparam logic [2:0] CFG_SETPOINT  = 3'd0;
    localparam logic [2:0] CFG_INT_GAIN  = 3'd1;
    localparam logic [2:0] CFG_DER_GAIN  = 3'd2;
    localparam logic [2:0] CFG_TICK_PER  = 3'd3;
    localparam logic [2:0] CFG_TICK_RATE = 3'd4;

    // multiplier operand A
    localparam logic [2:0] A_ERR    = 3'd0;
    localparam logic [2:0] A_DIFF   = 3'd1;
    localparam logic [2:0] A_POTNUM = 3'd2;
    localparam logic [2:0] A_ILO    = 3'd3;
    localparam logic [2:0] A_IHI    = 3'd4;
    localparam logic [2:0] A_TMP    = 3'd5;
    localparam logic [2:0] A_ROUND  = 3'd6;

    // multiplier operand B
    localparam logic [2:0] B_PERIOD  = 3'd0;
    localparam logic [2:0] B_KP      = 3'd1;
    localparam logic [2:0] B_IG      = 3'd2;
    localparam logic [2:0] B_DG      = 3'd3;
    localparam logic [2:0] B_RATE    = 3'd4;
    localparam logic [2:0] B_RCP1023 = 3'd5;
    localparam logic [2:0] B_RCP5    = 3'd6;

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_KP        = 4'd2;
    localparam logic [3:0] OP_INTEG     = 4'd3;
    localparam logic [3:0] OP_TMP       = 4'd4;
    localparam logic [3:0] OP_ACC_LD    = 4'd5;
    localparam logic [3:0] OP_ACC_ADD24 = 4'd6;
    localparam logic [3:0] OP_ACC_SHR16 = 4'd7;
    localparam logic [3:0] OP_ACC_ADD   = 4'd8;
    localparam logic [3:0] OP_ACC_ADD8  = 4'd9;
    localparam logic [3:0] OP_CLAMP     = 4'd10;
    localparam logic [3:0] OP_FINISH    = 4'd11;

    // step hold conditions
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_IN   = 2'd1;
    localparam logic [1:0] HOLD_OUT  = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [3:0] op;
        logic [1:0] hold;
        logic       last;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_cond;

    localparam t_ctrl CTRL_NOP = '{
        mul_en: 1'b0, a_sel: A_ERR, b_sel: B_PERIOD,
        op: OP_NOP, hold: HOLD_NONE, last: 1'b1
    };

    // ceil(2^35/1023) and ceil(2^18/5)
    localparam logic [MB_W-1:0] RCP1023 = 27'd33587233;
    localparam logic [MB_W-1:0] RCP5    = 27'd52429;
    localparam int RCP1023_SH = 35;
    localparam int RCP5_SH    = 18;

    localparam logic [24:0] POT_ROUND = 25'd511;
    localparam logic [MAG_W-1:0] ANGLE_HALF = 25'd1280;

    localparam logic signed [ACC_W-1:0] SUM_LIMIT = 64'sd29491200;
    localparam logic signed [INT_W-1:0] INT_MAX   = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN   = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic signed [14:0] ANGLE_MAX = 15'sd11520;

endpackage
`default_nettype wire

// ===== rtl/pid_position_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pid_position_step
// Position PID step with output clamp: error, saturating integral, derivative,
// clamped sum and inverted angle mapping on one shared multiplier, sequenced
// by a 13-step microcode program.
// ============================================================================
// Inputs pass one at a time through the 13 microcode steps on the single
//   34x27 multiplier; the final step holds while a result waits.
// Reset: registers to their defaults, integral and last error cleared.
// Configuration writes are accepted whenever out of reset (ready high).
// ============================================================================
module pid_position_step
    import pps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_pid_in     i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_pid_out         o_out
);

    logic [15:0]       r_setpoint;
    logic [GAIN_W-1:0] r_int_gain;
    logic [GAIN_W-1:0] r_der_gain;
    logic [23:0]       r_tick_per;
    logic [15:0]       r_tick_rate;

    logic signed [INT_W-1:0]  r_int;
    logic signed [ERR_W-1:0]  r_last_err;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic [9:0]               r_pot;
    logic [GAIN_W-1:0]        r_kp;
    logic signed [MA_W-1:0]   r_tmp;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic                     r_clamped;
    logic                     r_out_valid;
    t_pid_out                 r_out;

    t_ctrl ctrl;
    t_cond cond;
    logic  fire;
    logic  in_acc;
    logic  finish;

    logic signed [ERR_W-1:0]  new_err;
    logic [24:0]              pot_num;
    logic [MAG_W-1:0]         round_sum;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [INT_W:0]    int_sum;
    logic signed [INT_W-1:0]  int_sat;
    logic signed [ACC_W-1:0]  prod_x;
    logic signed [ACC_W-1:0]  acc_abs;
    logic                     over_pos;
    logic                     over_neg;
    logic [14:0]              q_ext;

    assign cond.in_valid = i_in_valid;
    assign cond.out_busy = r_out_valid && !i_out_ready;

    pps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl),
        .o_fire  (fire)
    );

    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = i_rst_n && (ctrl.op == OP_LOAD);
    assign in_acc      = i_in_valid && o_in_ready;
    assign finish      = fire && (ctrl.op == OP_FINISH);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign new_err   = $signed({1'b0, r_setpoint}) - $signed({1'b0, i_in.distance});
    assign pot_num   = {1'b0, i_in.gain_pot, 14'b0} + {2'b0, r_pot, 13'b0}
                     + {5'b0, r_pot, 10'b0} + POT_ROUND - {1'b0, i_in.gain_pot, 14'b0}
                     + {1'b0, r_pot, 14'b0};
    assign round_sum = r_mag + ANGLE_HALF;

    always_comb begin
        case (ctrl.a_sel)
            A_ERR:    mul_a = MA_W'(r_err);
            A_DIFF:   mul_a = MA_W'(r_diff);
            A_POTNUM: mul_a = $signed({{(MA_W-25){1'b0}}, pot_num});
            A_ILO:    mul_a = $signed({{(MA_W-24){1'b0}}, r_int[23:0]});
            A_IHI:    mul_a = MA_W'($signed(r_int[INT_W-1:24]));
            A_TMP:    mul_a = r_tmp;
            A_ROUND:  mul_a = $signed({{(MA_W-16){1'b0}}, round_sum[24:9]});
            default:  mul_a = '0;
        endcase
        case (ctrl.b_sel)
            B_PERIOD:  mul_b = $signed({{(MB_W-24){1'b0}}, r_tick_per});
            B_KP:      mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, r_kp});
            B_IG:      mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, r_int_gain});
            B_DG:      mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, r_der_gain});
            B_RATE:    mul_b = $signed({{(MB_W-16){1'b0}}, r_tick_rate});
            B_RCP1023: mul_b = $signed(RCP1023);
            B_RCP5:    mul_b = $signed(RCP5);
            default:   mul_b = '0;
        endcase
    end

    always_comb begin
        int_sum = $signed({r_int[INT_W-1], r_int}) + $signed(r_prod[INT_W:0]);
        if (int_sum[INT_W] != int_sum[INT_W-1]) begin
            int_sat = int_sum[INT_W] ? INT_MIN : INT_MAX;
        end else begin
            int_sat = int_sum[INT_W-1:0];
        end
        prod_x   = ACC_W'(r_prod);
        acc_abs  = r_acc[ACC_W-1] ? -r_acc : r_acc;
        over_pos = r_acc > SUM_LIMIT;
        over_neg = r_acc < -SUM_LIMIT;
        q_ext    = {1'b0, r_prod[RCP5_SH+Q_W-1:RCP5_SH]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= '0;
            r_int_gain  <= '0;
            r_der_gain  <= '0;
            r_tick_per  <= 24'd267371;
            r_tick_rate <= 16'd16064;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SETPOINT:  r_setpoint  <= i_cfg_data[15:0];
                CFG_INT_GAIN:  r_int_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_DER_GAIN:  r_der_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_TICK_PER:  r_tick_per  <= i_cfg_data;
                CFG_TICK_RATE: r_tick_rate <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int       <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_last_err <= new_err;
            end
            if (fire && ctrl.op == OP_INTEG) begin
                r_int <= int_sat;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (fire) begin
            case (ctrl.op)
                OP_LOAD: begin
                    r_err  <= new_err;
                    r_diff <= DIFF_W'(new_err) - DIFF_W'(r_last_err);
                    r_pot  <= i_in.gain_pot;
                end
                OP_KP:        r_kp  <= r_prod[RCP1023_SH+GAIN_W-1:RCP1023_SH];
                OP_TMP:       r_tmp <= r_prod[MA_W-1:0];
                OP_ACC_LD:    r_acc <= prod_x;
                OP_ACC_ADD24: r_acc <= r_acc + (prod_x <<< 24);
                OP_ACC_SHR16: r_acc <= r_acc >>> 16;
                OP_ACC_ADD:   r_acc <= r_acc + prod_x;
                OP_ACC_ADD8:  r_acc <= r_acc + (prod_x <<< 8);
                OP_CLAMP: begin
                    r_clamped <= over_pos || over_neg;
                    r_neg     <= r_acc[ACC_W-1];
                    if (over_pos || over_neg) begin
                        r_mag <= SUM_LIMIT[MAG_W-1:0];
                    end else begin
                        r_mag <= acc_abs[MAG_W-1:0];
                    end
                end
                OP_FINISH: begin
                    r_out.angle_target <= r_neg ? $signed(q_ext) : $signed(-q_ext);
                    r_out.clamped      <= r_clamped;
                end
                default: begin
                end
            endcase
        end
    end

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input taken twice within one pass");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(finish))
        else $error("result raised outside the final step");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.angle_target <= ANGLE_MAX)
                     && (o_out.angle_target >= -ANGLE_MAX))
        else $error("angle beyond full scale");

    a_clamp_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.clamped) |-> (o_out.angle_target == ANGLE_MAX)
                                        || (o_out.angle_target == -ANGLE_MAX))
        else $error("clamped result not at full scale");

endmodule
`default_nettype wire

// ===== rtl/pps_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pps_seq
// Step counter and microcode ROM. One control word per step; a step may hold
// on an input or output condition, and the last step jumps back to the start.
// ============================================================================
module pps_seq
    import pps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cond i_cond,
    output t_ctrl      o_ctrl,
    output logic       o_fire
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w;

    always_comb begin
        w = CTRL_NOP;
        w.last = 1'b0;
        case (r_step)
            4'd0: begin
                w.op   = OP_LOAD;
                w.hold = HOLD_IN;
            end
            4'd1: begin
                w.mul_en = 1'b1; w.a_sel = A_POTNUM; w.b_sel = B_RCP1023;
            end
            4'd2: begin
                w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_PERIOD;
                w.op = OP_KP;
            end
            4'd3: begin
                w.mul_en = 1'b1; w.a_sel = A_DIFF; w.b_sel = B_DG;
                w.op = OP_INTEG;
            end
            4'd4: begin
                w.mul_en = 1'b1; w.a_sel = A_ILO; w.b_sel = B_IG;
                w.op = OP_TMP;
            end
            4'd5: begin
                w.mul_en = 1'b1; w.a_sel = A_IHI; w.b_sel = B_IG;
                w.op = OP_ACC_LD;
            end
            4'd6: begin
                w.mul_en = 1'b1; w.a_sel = A_TMP; w.b_sel = B_RATE;
                w.op = OP_ACC_ADD24;
            end
            4'd7: begin
                w.op = OP_ACC_SHR16;
            end
            4'd8: begin
                w.mul_en = 1'b1; w.a_sel = A_ERR; w.b_sel = B_KP;
                w.op = OP_ACC_ADD;
            end
            4'd9: begin
                w.op = OP_ACC_ADD8;
            end
            4'd10: begin
                w.op = OP_CLAMP;
            end
            4'd11: begin
                w.mul_en = 1'b1; w.a_sel = A_ROUND; w.b_sel = B_RCP5;
            end
            4'd12: begin
                w.op   = OP_FINISH;
                w.hold = HOLD_OUT;
                w.last = 1'b1;
            end
            default: begin
                w = CTRL_NOP;
            end
        endcase
    end

    always_comb begin
        case (w.hold)
            HOLD_IN:  o_fire = i_cond.in_valid;
            HOLD_OUT: o_fire = !i_cond.out_busy;
            default:  o_fire = 1'b1;
        endcase
        if (!o_fire) begin
            n_step = r_step;
        end else if (w.last) begin
            n_step = '0;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    assign o_ctrl = w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire
